// ===== design/delimited_segment_deframer_defines.svh =====
// Assertion macros used by the deframer RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef DELIMITED_SEGMENT_DEFRAMER_DEFINES_SVH
`define DELIMITED_SEGMENT_DEFRAMER_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define DSD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another one at the next clock edge.
`define DSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dsd_pkg
// Types, codes and frame-format constants for the segment deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsd_pkg;

  localparam logic [15:0] HEADER_BYTES  = 16'd24;
  localparam logic [15:0] LENGTH_OFFSET = 16'd16;
  localparam logic [15:0] MAX_PAYLOAD   = 16'd1024;
  localparam logic [15:0] NODE_BYTES    = 16'd4;

  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam logic [15:0] SUM_GOOD = 16'hffff;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_NODE,
    PH_HDR,
    PH_DATA,
    PH_STOP1,
    PH_STOP2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_DATA,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    ST_GOOD,
    ST_BAD,
    ST_LONG
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         byte_value;
    logic [9:0]         byte_index;
    logic signed [31:0] node_id;
    logic [15:0]        payload_length;
    status_t            status;
  } evt_t;

  // 16-bit ones'-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== design/dsd_front.sv =====
// ----------------------------------------------------------------------------
// dsd_front
// Frame parser: takes one byte per item, tracks the frame phase, the node id,
// the length field and the checksum, and pushes one result record per event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          evt_push,
  output dsd_pkg::evt_t evt
);
  import dsd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [15:0]        pos_r, pos_nxt;
  logic signed [31:0] node_r, node_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic               odd_r, odd_nxt;

  logic        accept;
  logic        gen;
  logic [15:0] pos_inc;
  logic [15:0] fin_sum;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign evt_push = accept && gen;
  assign pos_inc  = pos_r + 16'd1;
  assign fin_sum  = odd_r ? ones_add(sum_r, {8'd0, pend_r}) : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      pos_r   <= '0;
      node_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      pend_r  <= '0;
      odd_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      node_r  <= node_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
      odd_r   <= odd_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    node_nxt  = node_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    odd_nxt   = odd_r;
    gen       = 1'b0;
    evt       = '0;

    // header and payload bytes enter the checksum as little-endian words
    if (phase_r == PH_HDR || phase_r == PH_DATA) begin
      if (!odd_r) begin
        pend_nxt = in_byte;
        odd_nxt  = 1'b1;
      end else begin
        sum_nxt = ones_add(sum_r, {in_byte, pend_r});
        odd_nxt = 1'b0;
      end
    end

    case (phase_r)
      PH_HUNT2: begin
        if (in_byte == CH_AMP) begin
          phase_nxt = PH_NODE;
          pos_nxt   = '0;
          node_nxt  = '0;
          len_nxt   = '0;
          sum_nxt   = '0;
          pend_nxt  = '0;
          odd_nxt   = 1'b0;
        end else begin
          phase_nxt = (in_byte == CH_BANG) ? PH_HUNT2 : PH_HUNT1;
        end
      end
      PH_NODE: begin
        // node bytes past the fourth are consumed only
        if (pos_r < 16'd4) begin
          node_nxt[{pos_r[1:0], 3'b000} +: 8] = in_byte;
        end
        pos_nxt = pos_inc;
        if (pos_inc >= NODE_BYTES) begin
          phase_nxt = PH_HDR;
          pos_nxt   = '0;
        end
      end
      PH_HDR: begin
        if (pos_r == LENGTH_OFFSET) begin
          len_nxt[7:0] = in_byte;
        end else if (pos_r == LENGTH_OFFSET + 16'd1) begin
          len_nxt[15:8] = in_byte;
        end
        gen              = 1'b1;
        evt.kind         = KIND_HDR;
        evt.byte_value   = in_byte;
        evt.byte_index   = pos_r[9:0];
        pos_nxt          = pos_inc;
        if (pos_inc >= HEADER_BYTES) begin
          pos_nxt = '0;
          if (len_nxt > MAX_PAYLOAD) begin
            // oversized frame ends here in place of the header-byte item
            phase_nxt          = PH_HUNT1;
            evt.kind           = KIND_END;
            evt.byte_value     = '0;
            evt.byte_index     = '0;
            evt.node_id        = node_r;
            evt.payload_length = len_nxt;
            evt.status         = ST_LONG;
          end else begin
            phase_nxt = (len_nxt == 16'd0) ? PH_STOP1 : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        gen            = 1'b1;
        evt.kind       = KIND_DATA;
        evt.byte_value = in_byte;
        evt.byte_index = pos_r[9:0];
        pos_nxt        = pos_inc;
        if (pos_inc >= len_r) begin
          phase_nxt = PH_STOP1;
          pos_nxt   = '0;
        end
      end
      PH_STOP1: begin
        phase_nxt = (in_byte == CH_BANG) ? PH_STOP2 : PH_HUNT1;
      end
      PH_STOP2: begin
        if (in_byte == CH_HASH) begin
          phase_nxt          = PH_HUNT1;
          gen                = 1'b1;
          evt.kind           = KIND_END;
          evt.node_id        = node_r;
          evt.payload_length = len_r;
          evt.status         = (fin_sum == SUM_GOOD) ? ST_GOOD : ST_BAD;
        end else begin
          // reexamine the byte as a hunting byte
          phase_nxt = (in_byte == CH_BANG) ? PH_HUNT2 : PH_HUNT1;
        end
      end
      default: begin
        phase_nxt = (in_byte == CH_BANG) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

endmodule

// ===== design/dsd_queue.sv =====
// ----------------------------------------------------------------------------
// dsd_queue
// Small result queue between the parser and the output channel; its head
// entry drives the output, so each side stalls on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "delimited_segment_deframer_defines.svh"

module dsd_queue #(
  parameter int QDEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dsd_pkg::evt_t push_evt,
  output logic          full,
  output logic          head_valid,
  input  logic          pop_ready,
  output dsd_pkg::evt_t head_evt
);
  import dsd_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

  evt_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign pop        = head_valid && pop_ready;
  assign head_evt   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_evt;
    end
  end

  `DSD_ASSERT_ALWAYS(a_no_push_full, (!push || !full), "push into a full result queue")
  `DSD_ASSERT_ALWAYS(a_count_range, (count_r <= FULL_CNT), "result queue count out of range")
  `DSD_ASSERT_NEXT(a_push_grows, (push && !pop), (count_r == $past(count_r) + 1'b1), "queue count did not grow")
  `DSD_ASSERT_NEXT(a_pop_shrinks, (pop && !push), (count_r == $past(count_r) - 1'b1), "queue count did not shrink")

endmodule

// ===== design/delimited_segment_deframer.sv =====
// Result path: a result item is queued, then offered on out_ from the queue head.
// Throughput: one byte accepted per cycle; a stalled output is absorbed by a
//   QDEPTH-entry result queue, and in_tready drops only while that queue is full.
// Reset: synchronous, active low; clears the parser to start-marker hunting and
//   empties the result queue.
// ----------------------------------------------------------------------------
// delimited_segment_deframer
// Deframes marker-delimited segments, emits header and payload bytes with their
// index and a frame-end item with node id, length and checksum or oversize status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_segment_deframer #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] byte_value, [17:8] byte_index, [49:18] node_id,
  // [65:50] payload_length, [67:66] status, [71:68] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] kind
);
  import dsd_pkg::*;

  logic q_full;
  logic evt_push;
  evt_t evt;
  evt_t head;

  dsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .evt_push (evt_push),
    .evt      (evt)
  );

  dsd_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (evt_push),
    .push_evt   (evt),
    .full       (q_full),
    .head_valid (out_tvalid),
    .pop_ready  (out_tready),
    .head_evt   (head)
  );

  assign out_tuser = head.kind;
  assign out_tdata = {4'd0, head.status, head.payload_length, head.node_id,
                      head.byte_index, head.byte_value};

endmodule
